[hdl/vlal_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlal_pkg
// Shared codes, constants and controller/datapath interface types of the
// video-to-audio leak block.
// ----------------------------------------------------------------------------
package vlal_pkg;

  localparam logic [2:0] CMD_TABLE = 3'd0;
  localparam logic [2:0] CMD_PIXEL = 3'd1;
  localparam logic [2:0] CMD_LINE  = 3'd2;
  localparam logic [2:0] CMD_FRAME = 3'd3;
  localparam logic [2:0] CMD_AUDIO = 3'd4;

  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] CFG_FIRST_LINE  = 2'd1;
  localparam logic [1:0] CFG_LAST_LINE   = 2'd2;
  localparam logic [1:0] CFG_LEAK_ENABLE = 2'd3;

  // Divider operand selections.
  localparam logic [2:0] DSEL_LINE  = 3'd0;
  localparam logic [2:0] DSEL_FRAME = 3'd1;
  localparam logic [2:0] DSEL_NOISE = 3'd3;
  localparam logic [2:0] DSEL_LPH   = 3'd4;

  localparam int SUM_W  = 48;
  localparam int DVSR_W = 22;

  localparam logic [17:0] NOISE_HZ = 18'd44100;
  localparam logic [17:0] LINE_HZ  = 18'd15000;
  // ceil(2^18 / 5): exact division by five for operands below 2^18.
  localparam logic [15:0] DIV5_RECIP = 16'd52429;
  localparam logic signed [47:0] PIX_OFFSET = 48'sd65536;
  localparam logic [11:0] COUNT_FULL = 12'd4095;

  localparam logic [1:0] NOISE_PATTERN [16] = '{
    2'd2, 2'd1, 2'd1, 2'd1, 2'd3, 2'd2, 2'd1, 2'd1,
    2'd2, 2'd1, 2'd1, 2'd1, 2'd3, 2'd2, 2'd1, 2'd1
  };

  typedef struct packed {
    logic       latch_in;
    logic       tbl_wr;
    logic       px_add;
    logic       div_start;
    logic [2:0] dsel;
    logic       line_wr;
    logic       frame_wr;
    logic       mul_ld;
    logic       t1_ld;
    logic       t1_fin;
    logic       res_ld;
    logic       pass_ld;
    logic       noise_upd;
    logic       lph_upd;
    logic       step;
    logic       load_out;
    logic       clr;
  } vlal_cmd_t;

  typedef struct packed {
    logic [2:0] cmd_code;
    logic       clr_last;
    logic       div_done;
    logic       count_zero;
    logic       frame_ok;
    logic       enable;
    logic       steps_zero;
    logic       out_free;
  } vlal_stat_t;

endpackage
`default_nettype wire

[hdl/vlal_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlal_div
// Radix-2 restoring divider, one quotient bit per cycle, signed dividend,
// unsigned divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module vlal_div
  import vlal_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  input  wire logic signed [47:0] dividend,
  input  wire logic [21:0]        divisor,
  output logic                    done,
  output logic signed [47:0]      quot,
  output logic [21:0]             rem
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [47:0] a_r;
  logic [21:0] rem_r;
  logic [21:0] dvs_r;
  logic        neg_r;

  logic [22:0] rem_sh;
  logic        ge;
  logic [22:0] rem_sub;

  assign rem_sh  = {rem_r, a_r[47]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dividend[47] ? 48'(-dividend) : dividend;
      neg_r <= dividend[47];
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      a_r   <= {a_r[46:0], ge};
      rem_r <= ge ? rem_sub[21:0] : rem_sh[21:0];
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(a_r) : $signed(a_r);
  assign rem  = rem_r;

endmodule
`default_nettype wire

[hdl/vlal_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlal_dp
// Datapath: configuration, luma tables, line store, sums, phases, the shared
// divider and the output register.
// ----------------------------------------------------------------------------
module vlal_dp
  import vlal_pkg::*;
#(
  parameter int MAX_LINES = 512
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [16:0]        cfg_data,
  input  wire logic [2:0]         in_command,
  input  wire logic [7:0]         in_table_index,
  input  wire logic signed [23:0] in_table_low,
  input  wire logic signed [23:0] in_table_high,
  input  wire logic [7:0]         in_pixel_value,
  input  wire logic signed [15:0] in_sample_in,
  input  wire                     out_stall,
  output logic                    out_valid,
  output logic signed [15:0]      out_mixed_sample,
  input  wire vlal_cmd_t          cmd,
  output vlal_stat_t              stat
);

  localparam int LW = $clog2(MAX_LINES);

  logic [16:0] rate_cfg_r;
  logic [8:0]  first_r;
  logic [8:0]  last_r;
  logic        enable_r;

  logic [2:0]         cmd_code_r;
  logic [7:0]         ti_r;
  logic [23:0]        tlo_r;
  logic [23:0]        thi_r;
  logic [7:0]         px_r;
  logic signed [15:0] smp_r;

  logic [23:0] low_mem  [256];
  logic [23:0] high_mem [256];
  logic [23:0] low_q_r;
  logic [23:0] high_q_r;
  logic [31:0] store_mem [MAX_LINES];
  logic [31:0] store_q_r;
  logic [LW-1:0] clr_addr_r;

  logic signed [47:0] sum_r;
  logic [11:0]        count_r;
  logic signed [47:0] frame_r;
  logic [LW-1:0]      wslot_r;
  logic signed [31:0] avg_r;
  logic [3:0]         pos_r;
  logic [LW-1:0]      rslot_r;
  logic [16:0]        np_r;
  logic [16:0]        lp_r;
  logic [17:0]        steps_r;
  logic signed [37:0] prod_r;
  logic [16:0]        t1_mag_r;
  logic               t1_neg_r;
  logic signed [16:0] t1_r;
  logic signed [15:0] res_r;
  logic               out_valid_r;
  logic signed [15:0] out_data_r;

  // Configuration is accepted at any time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_cfg_r <= 17'd22050;
      first_r    <= '0;
      last_r     <= '0;
      enable_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_RATE: rate_cfg_r <= cfg_data;
        CFG_FIRST_LINE:  first_r    <= cfg_data[8:0];
        CFG_LAST_LINE:   last_r     <= cfg_data[8:0];
        CFG_LEAK_ENABLE: enable_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_code_r <= in_command;
      ti_r       <= in_table_index;
      tlo_r      <= in_table_low;
      thi_r      <= in_table_high;
      px_r       <= in_pixel_value;
      smp_r      <= in_sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      low_mem[ti_r]  <= tlo_r;
      high_mem[ti_r] <= thi_r;
    end
    low_q_r  <= low_mem[px_r];
    high_q_r <= high_mem[px_r];
  end

  // Divider and its operand selection.
  logic signed [47:0] div_a;
  logic [21:0]        div_b;
  logic               div_done;
  logic signed [47:0] div_q;
  logic [21:0]        div_rem;
  logic [14:0]        count5;
  logic [16:0]        rate;
  logic [17:0]        np_sum;
  logic [17:0]        lp_sum;

  assign count5 = {3'b000, count_r} * 15'd5;
  assign rate   = (rate_cfg_r == 17'd0) ? 17'd1 : rate_cfg_r;
  assign np_sum = {1'b0, np_r} + NOISE_HZ;
  assign lp_sum = {1'b0, lp_r} + LINE_HZ;

  always_comb begin
    case (cmd.dsel)
      DSEL_LINE: begin
        div_a = sum_r;
        div_b = {7'd0, count5};
      end
      DSEL_FRAME: begin
        div_a = frame_r;
        div_b = {13'd0, 9'(last_r - first_r)};
      end
      DSEL_NOISE: begin
        div_a = {30'd0, np_sum};
        div_b = {5'd0, rate};
      end
      DSEL_LPH: begin
        div_a = {30'd0, lp_sum};
        div_b = {5'd0, rate};
      end
      default: begin
        div_a = '0;
        div_b = 22'd1;
      end
    endcase
  end

  vlal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // First line reduced into the store.
  logic [10:0]   first_tmp;
  logic [LW-1:0] first_mod;
  always_comb begin
    first_tmp = {2'b00, first_r};
    for (int i = 0; i < 8; i++) begin
      if (first_tmp >= 11'(MAX_LINES)) first_tmp = first_tmp - 11'(MAX_LINES);
    end
    first_mod = first_tmp[LW-1:0];
  end

  logic count_zero;
  logic frame_ok;
  assign count_zero = count_r == 12'd0;
  assign frame_ok   = last_r > first_r;

  logic signed [47:0] line_v;
  logic signed [47:0] pix_w;
  logic signed [31:0] avg_sat;
  logic               q_fits;
  assign line_v = count_zero ? 48'sd0 : div_q;
  assign pix_w  = ({{24{low_q_r[23]}}, low_q_r} <<< 2)
                + {{24{high_q_r[23]}}, high_q_r} + PIX_OFFSET;
  assign q_fits = (div_q[47:31] == 17'd0) || (div_q[47:31] == 17'h1FFFF);
  assign avg_sat = q_fits ? div_q[31:0]
                 : (div_q[47] ? 32'sh80000000 : 32'sh7FFFFFFF);

  // Noise term: the magnitude is divided by 2^19 with a shift, then by five
  // with a reciprocal multiply, and the sign is put back afterwards.
  logic [5:0]  coef;
  logic [37:0] prod_abs;
  logic [32:0] t1_mul;
  logic [16:0] t1_quo;
  assign coef     = {1'b0, {3'b000, NOISE_PATTERN[pos_r]} * 5'd9};
  assign prod_abs = prod_r[37] ? -prod_r : prod_r;
  assign t1_mul   = {16'd0, t1_mag_r} * {17'd0, DIV5_RECIP};
  assign t1_quo   = {2'b00, t1_mul[32:18]};

  // Mixing terms.
  logic signed [33:0] line_x3;
  logic signed [33:0] line_bias;
  logic signed [16:0] t2;
  logic signed [18:0] mix;
  logic signed [15:0] mix_sat;
  assign line_x3   = {{2{store_q_r[31]}}, store_q_r} + {store_q_r[31], store_q_r, 1'b0};
  assign line_bias = line_x3[33] ? line_x3 + 34'sd131071 : line_x3;
  assign t2        = line_bias[33:17];
  assign mix       = {{3{smp_r[15]}}, smp_r} + {{2{t1_r[16]}}, t1_r}
                   + {{2{t2[16]}}, t2};
  assign mix_sat   = (mix > 19'sd32767) ? 16'sh7FFF
                   : (mix < -19'sd32768) ? 16'sh8000 : mix[15:0];

  // Playback slot step.
  logic [LW-1:0] rslot_next;
  assign rslot_next = ((11'(rslot_r) >= {2'b00, last_r}) ||
                       (11'(rslot_r) + 11'd1 >= 11'(MAX_LINES)))
                    ? first_mod : rslot_r + 1'b1;

  logic [LW-1:0] wslot_next;
  assign wslot_next = (11'(wslot_r) + 11'd1 >= 11'(MAX_LINES)) ? '0 : wslot_r + 1'b1;

  // Line store, cleared by a sweep after reset.
  always_ff @(posedge clk) begin
    if (cmd.clr) store_mem[clr_addr_r] <= '0;
    else if (cmd.line_wr) store_mem[wslot_r] <= line_v[31:0];
    store_q_r <= store_mem[rslot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr) clr_addr_r <= clr_addr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
      frame_r <= '0;
      wslot_r <= '0;
      avg_r   <= '0;
      pos_r   <= '0;
      rslot_r <= '0;
      np_r    <= '0;
      lp_r    <= '0;
      steps_r <= '0;
    end else begin
      if (cmd.px_add && count_r != COUNT_FULL) begin
        sum_r   <= sum_r + pix_w;
        count_r <= count_r + 12'd1;
      end
      if (cmd.line_wr) begin
        frame_r <= frame_r + line_v;
        wslot_r <= wslot_next;
        sum_r   <= '0;
        count_r <= '0;
      end
      if (cmd.frame_wr) begin
        avg_r   <= frame_ok ? avg_sat : 32'sd0;
        frame_r <= '0;
        wslot_r <= first_mod;
      end
      if (cmd.noise_upd) begin
        pos_r <= pos_r + div_q[3:0];
        np_r  <= div_rem[16:0];
      end
      if (cmd.lph_upd) begin
        steps_r <= div_q[17:0];
        lp_r    <= div_rem[16:0];
      end
      if (cmd.step) begin
        steps_r <= steps_r - 18'd1;
        rslot_r <= rslot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_ld)  prod_r <= avg_r * $signed(coef);
    if (cmd.t1_ld) begin
      t1_mag_r <= prod_abs[35:19];
      t1_neg_r <= prod_r[37];
    end
    if (cmd.t1_fin)  t1_r   <= t1_neg_r ? 17'(-t1_quo) : t1_quo;
    if (cmd.res_ld)  res_r  <= mix_sat;
    if (cmd.pass_ld) res_r  <= smp_r;
    if (cmd.load_out) out_data_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_data_r;

  assign stat.cmd_code   = cmd_code_r;
  assign stat.clr_last   = clr_addr_r == LW'(MAX_LINES - 1);
  assign stat.div_done   = div_done;
  assign stat.count_zero = count_zero;
  assign stat.frame_ok   = frame_ok;
  assign stat.enable     = enable_r;
  assign stat.steps_zero = steps_r == 18'd0;
  assign stat.out_free   = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

[hdl/vlal_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlal_ctrl
// Controller: sequences the clearing sweep and each command through the
// datapath.
// ----------------------------------------------------------------------------
module vlal_ctrl
  import vlal_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  output vlal_cmd_t       cmd,
  input  wire vlal_stat_t stat
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_PXADD = 4'd3;
  localparam logic [3:0] S_LDIV  = 4'd4;
  localparam logic [3:0] S_FDIV  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_T1    = 4'd7;
  localparam logic [3:0] S_NDIV  = 4'd8;
  localparam logic [3:0] S_LPDIV = 4'd9;
  localparam logic [3:0] S_STEP  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.cmd_code)
          CMD_TABLE: begin
            cmd.tbl_wr = 1'b1;
            state_nxt  = S_IDLE;
          end
          CMD_PIXEL: state_nxt = S_PXADD;
          CMD_LINE: begin
            if (stat.count_zero) begin
              cmd.line_wr = 1'b1;
              state_nxt   = S_IDLE;
            end else begin
              cmd.div_start = 1'b1;
              cmd.dsel      = DSEL_LINE;
              state_nxt     = S_LDIV;
            end
          end
          CMD_FRAME: begin
            if (!stat.frame_ok) begin
              cmd.frame_wr = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              cmd.div_start = 1'b1;
              cmd.dsel      = DSEL_FRAME;
              state_nxt     = S_FDIV;
            end
          end
          CMD_AUDIO: begin
            if (stat.enable) begin
              cmd.mul_ld = 1'b1;
              state_nxt  = S_MUL;
            end else begin
              cmd.pass_ld = 1'b1;
              state_nxt   = S_OUT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_PXADD: begin
        cmd.px_add = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_LDIV: begin
        if (stat.div_done) begin
          cmd.line_wr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_FDIV: begin
        if (stat.div_done) begin
          cmd.frame_wr = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.t1_ld = 1'b1;
        state_nxt = S_T1;
      end
      S_T1: begin
        cmd.t1_fin    = 1'b1;
        cmd.div_start = 1'b1;
        cmd.dsel      = DSEL_NOISE;
        state_nxt     = S_NDIV;
      end
      S_NDIV: begin
        if (stat.div_done) begin
          cmd.res_ld    = 1'b1;
          cmd.noise_upd = 1'b1;
          cmd.div_start = 1'b1;
          cmd.dsel      = DSEL_LPH;
          state_nxt     = S_LPDIV;
        end
      end
      S_LPDIV: begin
        if (stat.div_done) begin
          cmd.lph_upd = 1'b1;
          state_nxt   = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.steps_zero) state_nxt = S_OUT;
        else cmd.step = 1'b1;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hdl/video_luma_audio_leak_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// video_luma_audio_leak_top
// Video-to-audio leak: gathers picture luma per line and frame and mixes a
// noise term and a replayed line term into audio samples.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_stall    command, table and pixel data,
//                                               sample_in
//   out_      output     out_valid / out_stall  mixed_sample (audio beats only)
//   cfg_      input      cfg_we                 cfg_index, cfg_data
//
// Table write, line end without pixels and frame end without division finish
// in the dispatch state; a pixel goes on to the add state and an audio beat
// with the leak off to the output state. A line or frame end with division
// waits for one 48-bit division in the shared restoring divider. An audio beat
// with the leak enabled scales the noise term, runs two divisions for the
// phases and then takes the playback line steps one at a time (up to 15000 at
// the lowest rate). After reset the line store is cleared by a sweep over all
// MAX_LINES slots before the first input beat is taken; configuration writes
// are taken throughout. A finished sample waits in the output register under
// out_stall while the next input beat is already being accepted.
//
module video_luma_audio_leak_top
  import vlal_pkg::*;
#(
  parameter int MAX_LINES = 512
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [16:0]        cfg_data,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_command,
  input  wire logic [7:0]         in_table_index,
  input  wire logic signed [23:0] in_table_low,
  input  wire logic signed [23:0] in_table_high,
  input  wire logic [7:0]         in_pixel_value,
  input  wire logic signed [15:0] in_sample_in,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic signed [15:0]      out_mixed_sample
);

  // Commands from the controller, status back from the datapath.
  vlal_cmd_t  cmd;
  vlal_stat_t stat;

  vlal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  vlal_dp #(
    .MAX_LINES (MAX_LINES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_command       (in_command),
    .in_table_index   (in_table_index),
    .in_table_low     (in_table_low),
    .in_table_high    (in_table_high),
    .in_pixel_value   (in_pixel_value),
    .in_sample_in     (in_sample_in),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_mixed_sample (out_mixed_sample),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule
`default_nettype wire

[test/tb_video_luma_audio_leak_top.sv]
// ----------------------------------------------------------------------------
// Testbench for video_luma_audio_leak_top
// Drives table, pixel, line, frame and audio beats through the valid/stall
// input channel, predicts every mixed audio sample from a behavioral model of
// the leak, and compares each output beat with the oldest prediction. Both
// channels idle and stall at random, and the configuration is changed
// between phases while the block is quiet.
// ----------------------------------------------------------------------------
module tb_video_luma_audio_leak_top
  import vlal_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES      = 512;
  localparam longint LIMIT  = 3000000;
  localparam int RAND_BEATS = 1500;

  // One input beat with every payload field.
  typedef struct {
    logic [2:0]         cmd;
    logic [7:0]         idx;
    logic signed [23:0] lo;
    logic signed [23:0] hi;
    logic [7:0]         px;
    logic signed [15:0] smp;
  } beat_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [1:0]              cfg_index;
  logic [16:0]             cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [2:0]              in_command;
  logic [7:0]              in_table_index;
  logic signed [23:0]      in_table_low;
  logic signed [23:0]      in_table_high;
  logic [7:0]              in_pixel_value;
  logic signed [15:0]      in_sample_in;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [15:0]      out_mixed_sample;

  video_luma_audio_leak_top #(.MAX_LINES(LINES)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_table_index(in_table_index),
    .in_table_low(in_table_low), .in_table_high(in_table_high),
    .in_pixel_value(in_pixel_value), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_mixed_sample(out_mixed_sample)
  );

  // Shadow of the block's state and registers, kept by the leak predictor.
  int          low_tbl [256];
  int          high_tbl [256];
  bit          tbl_written [256];
  byte unsigned written_idx [$];
  int          line_store [LINES];
  longint      pix_sum, frame_sum;
  int unsigned pix_cnt, wr_slot, noise_pos, rd_slot, noise_ph, line_ph;
  int          avg_luma;
  int unsigned rate_reg, first_reg, last_reg;
  bit          enable_reg;

  const int noise_shape [16] = '{2, 1, 1, 1, 3, 2, 1, 1, 2, 1, 1, 1, 3, 2, 1, 1};

  // Mixed samples still owed by the block, oldest first.
  logic signed [15:0] pending_samples [$];

  int     mismatches;
  int     samples_seen;
  int     beats_sent;
  longint cycles;
  bit     burst;      // sender offers beats back to back when set
  bit     hold_req;   // asks the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake must still end the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d samples still pending", cycles,
               pending_samples.size());
      $display("video_luma_audio_leak_top regression: fail");
      $finish;
    end
  end

  function automatic longint wrap48(longint v);
    logic signed [47:0] t;
    t = v[47:0];
    return longint'(t);
  endfunction

  // Updates the shadow state for one accepted beat and queues the sample
  // that an audio beat produces.
  task automatic predict_leak(beat_t b);
    longint      w, v, a, line, t1, t2, r;
    int unsigned rate, steps, s;
    case (b.cmd)
      CMD_TABLE: begin
        low_tbl[b.idx]  = int'(b.lo);
        high_tbl[b.idx] = int'(b.hi);
      end
      CMD_PIXEL: begin
        if (pix_cnt < 4095) begin
          w = 4 * longint'(low_tbl[b.px]) + longint'(high_tbl[b.px]) + 65536;
          pix_sum = wrap48(pix_sum + w);
          pix_cnt++;
        end
      end
      CMD_LINE: begin
        v = 0;
        if (pix_cnt != 0) v = pix_sum / (5 * longint'(pix_cnt));
        line_store[wr_slot % LINES] = int'(v);
        frame_sum = wrap48(frame_sum + v);
        wr_slot = (wr_slot % LINES + 1) % LINES;
        pix_sum = 0;
        pix_cnt = 0;
      end
      CMD_FRAME: begin
        a = 0;
        if (last_reg > first_reg) begin
          a = frame_sum / longint'(last_reg - first_reg);
          if (a > 64'sd2147483647) a = 64'sd2147483647;
          if (a < -64'sd2147483648) a = -64'sd2147483648;
        end
        avg_luma = int'(a);
        frame_sum = 0;
        wr_slot = first_reg % LINES;
      end
      CMD_AUDIO: begin
        r = longint'(b.smp);
        if (enable_reg) begin
          rate = (rate_reg != 0) ? rate_reg : 1;
          line = longint'(line_store[rd_slot % LINES]);
          t1 = (longint'(noise_shape[noise_pos % 16]) * longint'(avg_luma) * 9) / 2621440;
          t2 = (line * 3) / 131072;
          r = r + t1 + t2;
          if (r > 32767) r = 32767;
          if (r < -32768) r = -32768;
          noise_ph += 44100;
          steps = noise_ph / rate;
          noise_ph = noise_ph % rate;
          noise_pos = (noise_pos + steps) % 16;
          line_ph += 15000;
          steps = line_ph / rate;
          line_ph = line_ph % rate;
          for (int i = 0; i < steps; i++) begin
            s = rd_slot % LINES;
            if (s >= last_reg || s + 1 >= LINES) rd_slot = first_reg % LINES;
            else rd_slot = s + 1;
          end
        end
        pending_samples.push_back(r[15:0]);
      end
      default: ;
    endcase
  endtask

  // Sends one beat after a random gap, or none when burst is set, and waits until the block takes it.
  task automatic send_beat(beat_t b);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command     <= b.cmd;
    in_table_index <= b.idx;
    in_table_low   <= b.lo;
    in_table_high  <= b.hi;
    in_pixel_value <= b.px;
    in_sample_in   <= b.smp;
    in_valid       <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_leak(b);
    if (b.cmd <= CMD_AUDIO) beats_sent++;
  endtask

  // A beat with every field random; callers overwrite what matters.
  function automatic beat_t random_fields(logic [2:0] c);
    beat_t b;
    b.cmd = c;
    b.idx = 8'($urandom);
    b.lo  = 24'($urandom);
    b.hi  = 24'($urandom);
    b.px  = 8'($urandom);
    b.smp = 16'($urandom);
    return b;
  endfunction

  task automatic send_table(logic [7:0] idx, logic signed [23:0] lo,
                            logic signed [23:0] hi);
    beat_t b;
    b = random_fields(CMD_TABLE);
    b.idx = idx;
    b.lo  = lo;
    b.hi  = hi;
    if (!tbl_written[idx]) begin
      tbl_written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
    send_beat(b);
  endtask

  // Pixels only ever name table entries that have been written.
  task automatic send_pixel(logic [7:0] px);
    beat_t b;
    b = random_fields(CMD_PIXEL);
    b.px = tbl_written[px] ? px : written_idx[$urandom_range(0, written_idx.size() - 1)];
    send_beat(b);
  endtask

  task automatic send_audio(logic signed [15:0] smp);
    beat_t b;
    b = random_fields(CMD_AUDIO);
    b.smp = smp;
    send_beat(b);
  endtask

  task automatic send_cmd(logic [2:0] c);
    send_beat(random_fields(c));
  endtask

  // Lets the block go quiet: every sample delivered, then enough cycles for
  // a line or frame division or a long playback step loop to finish.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat ((rate_reg < 1000) ? 16000 : 400) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[16:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_SAMPLE_RATE: rate_reg   = data & 32'h1FFFF;
      CFG_FIRST_LINE:  first_reg  = data & 32'h1FF;
      CFG_LAST_LINE:   last_reg   = data & 32'h1FF;
      CFG_LEAK_ENABLE: enable_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned rate, int unsigned first, int unsigned last,
                            bit en);
    settle();
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_FIRST_LINE, first);
    write_reg(CFG_LAST_LINE, last);
    write_reg(CFG_LEAK_ENABLE, 32'(en));
  endtask

  // Receiver: holds off a random number of cycles before each output beat
  // (none in burst mode), or one long stretch when asked, so the block backs up into its input.
  initial begin
    int hold;
    out_stall = 1'b1;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 300;
      end else begin
        hold = burst ? 0 : $urandom_range(0, 12);
      end
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Checker: each output beat against the oldest predicted sample.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      samples_seen++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected output beat: mixed_sample %0d", out_mixed_sample);
      end else begin
        if (out_mixed_sample !== pending_samples[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on sample %0d: expected %0d, actual %0d", samples_seen,
                     pending_samples[0], out_mixed_sample);
        end
        void'(pending_samples.pop_front());
      end
    end
  end

  // With the leak off, samples pass untouched, including both extremes, and
  // unknown commands are dropped without a result.
  task automatic test_passthrough();
    send_audio(16'sh7FFF);
    send_audio(-16'sh8000);
    send_audio(16'sh0000);
    send_cmd(3'd5);
    send_cmd(3'd6);
    send_cmd(3'd7);
  endtask

  // Table extremes, an empty line, lines of pixels, a frame, then audio that
  // saturates high and low.
  task automatic test_luma_mix();
    set_config(22050, 0, 3, 1'b1);
    send_table(8'd0, 24'sh7FFFFF, 24'sh7FFFFF);
    send_table(8'd255, -24'sh800000, -24'sh800000);
    send_table(8'd85, 24'sh123456, -24'sh000001);
    send_table(8'd170, -24'sh654321, 24'sh7FFFFF);
    send_cmd(CMD_LINE);                       // line without pixels
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd85);
    send_cmd(CMD_LINE);
    send_pixel(8'd255);
    send_pixel(8'd170);
    send_cmd(CMD_LINE);
    send_cmd(CMD_FRAME);
    send_audio(16'sh7FF0);
    send_audio(-16'sh7FF0);
    send_audio(16'sh7FFF);
    send_audio(-16'sh8000);
    send_audio(16'sh0100);
  endtask

  // A frame whose last line is not above the first gives a zero average;
  // slots wrap at the end of the store and playback wraps past it too.
  task automatic test_frame_and_wrap();
    set_config(8000, 511, 200, 1'b1);
    send_cmd(CMD_FRAME);
    for (int i = 0; i < 4; i++) begin
      send_pixel(8'd0);
      send_cmd(CMD_LINE);
    end
    for (int i = 0; i < 6; i++) send_audio(16'($urandom));
    set_config(96000, 505, 511, 1'b1);
    send_cmd(CMD_FRAME);
    for (int i = 0; i < 10; i++) begin
      send_pixel(i[0] ? 8'd255 : 8'd0);
      send_cmd(CMD_LINE);
    end
    send_cmd(CMD_FRAME);
    for (int i = 0; i < 12; i++) send_audio(16'($urandom));
  endtask

  // Sample rates of zero and one force thousands of playback steps; the largest rate is tried as well.
  task automatic test_rate_extremes();
    set_config(0, 0, 7, 1'b1);
    for (int i = 0; i < 3; i++) send_audio(16'($urandom));
    set_config(1, 2, 5, 1'b1);
    for (int i = 0; i < 3; i++) send_audio(16'($urandom));
    set_config(32'h1FFFF, 0, 7, 1'b1);
    for (int i = 0; i < 3; i++) send_audio(16'($urandom));
  endtask

  // The receiver stalls for a long stretch while beats keep coming.
  task automatic test_backpressure();
    set_config(44100, 0, 3, 1'b1);
    burst = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_audio(16'($urandom));
    burst = 1'b0;
  endtask

  // Random phases: mostly well-formed lines of pixels with line and frame
  // ends and audio, plus table writes and a little noise.
  task automatic test_random();
    int sent, phase_len, pick, sel;
    int unsigned rate, first, last;
    sent = 0;
    while (sent < RAND_BEATS) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: rate = 8000;
        1: rate = 96000;
        2: rate = 44100;
        default: rate = $urandom_range(8000, 96000);
      endcase
      first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 20);
      last  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : first + $urandom_range(0, 30);
      if (sel == 1) begin
        first = 0;
        last  = 511;
      end
      set_config(rate, first, last, $urandom_range(0, 5) != 0);
      burst = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(150, 250);
      for (int i = 0; i < phase_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) send_table(8'($urandom), 24'($urandom), 24'($urandom));
        else if (pick < 58) send_pixel(8'($urandom));
        else if (pick < 68) send_cmd(CMD_LINE);
        else if (pick < 71) send_cmd(CMD_FRAME);
        else if (pick < 96) send_audio(16'($urandom));
        else begin
          send_cmd(3'($urandom_range(5, 7)));
          i--;
          sent--;
        end
        sent++;
      end
    end
    burst = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SAMPLE_RATE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_command     = CMD_TABLE;
    in_table_index = '0;
    in_table_low   = '0;
    in_table_high  = '0;
    in_pixel_value = '0;
    in_sample_in   = '0;
    cycles         = 0;
    mismatches     = 0;
    samples_seen   = 0;
    beats_sent     = 0;
    burst          = 1'b0;
    hold_req       = 1'b0;
    rate_reg = 22050; first_reg = 0; last_reg = 0; enable_reg = 1'b0;
    pix_sum = 0; frame_sum = 0; pix_cnt = 0; wr_slot = 0; noise_pos = 0;
    rd_slot = 0; noise_ph = 0; line_ph = 0; avg_luma = 0;
    foreach (line_store[i]) line_store[i] = 0;
    foreach (tbl_written[i]) tbl_written[i] = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_passthrough();
    test_luma_mix();
    test_frame_and_wrap();
    test_rate_extremes();
    test_backpressure();
    test_random();

    settle();
    $display("Covered %0d input beats and %0d audio samples over table, pixel, line,",
             beats_sent, samples_seen);
    $display("frame and audio traffic with random stalls, wrap cases and rate extremes.");
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("video_luma_audio_leak_top regression: pass");
    end else begin
      $display("%0d mismatches, %0d samples missing", mismatches, pending_samples.size());
      $display("video_luma_audio_leak_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/vlal_pkg.sv
hdl/vlal_div.sv
hdl/vlal_dp.sv
hdl/vlal_ctrl.sv
hdl/video_luma_audio_leak_top.sv
test/tb_video_luma_audio_leak_top.sv
